>>> rtl/bpdrp_pkg.sv
// ----------------------------------------------------------------------------
// bpdrp_pkg: shared types and constants of the dual-ring byte pipe
// Function codes, status bytes, field widths and the index helper used by
// the core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdrp_pkg;

  // default ring depths
  localparam int DEF_RX_DEPTH = 4096;
  localparam int DEF_TX_DEPTH = 1024;

  // request function codes
  localparam logic [3:0] FN_STATUS   = 4'd0;
  localparam logic [3:0] FN_CPU_RD   = 4'd1;
  localparam logic [3:0] FN_CPU_WR   = 4'd2;
  localparam logic [3:0] FN_CPU_RST  = 4'd3;
  localparam logic [3:0] FN_NOTIFY   = 4'd4;
  localparam logic [3:0] FN_POP      = 4'd5;
  localparam logic [3:0] FN_PUSH     = 4'd6;
  localparam logic [3:0] FN_CLR_RST  = 4'd7;
  localparam logic [3:0] FN_LINK_SET = 4'd8;
  localparam logic [3:0] FN_QUERY    = 4'd9;

  localparam logic [7:0] STATUS_READY = 8'h02;
  localparam logic [7:0] STATUS_IDLE  = 8'h00;

  // result field widths
  localparam int RXF_W = 13;
  localparam int TXU_W = 11;
  localparam int CNT_W = 32;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 104;

  // where the result byte comes from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RX,
    SRC_TX
  } src_t;

  // one request after the ring update, waiting for the storage read
  typedef struct packed {
    logic [7:0]       rd_byte;
    src_t             src;
    logic             done;
    logic [RXF_W-1:0] rx_free;
    logic [TXU_W-1:0] tx_used;
    logic             rst_req;
    logic             link_up;
    logic             tx_pend;
    logic [CNT_W-1:0] to_cpu;
    logic [CNT_W-1:0] from_cpu;
  } stage_t;

  // true if the mark lies ahead of the index (signed 32-bit distance)
  function automatic logic mark_ahead(input logic [31:0] idx, input logic [31:0] mark);
    logic [31:0] d;
    d = mark - idx;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

`default_nettype wire

>>> rtl/bpdrp_ram.sv
// ----------------------------------------------------------------------------
// bpdrp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered and held while no
// read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/byte_pipe_dual_ring_port_core.sv
// ----------------------------------------------------------------------------
// byte_pipe_dual_ring_port_core: CPU / link byte pipe over two rings
// Receive and transmit rings with free-running 32-bit indices, lazy flush
// marks, port reset handshake and delivery counters.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  in      | in  | in_tvalid / in_tready  | in_tuser: func; in_tdata: data
//          |     |                        |   byte, link flag
//  out     | out | out_tvalid / out_tready| out_tdata: byte, done, levels,
//          |     |                        |   flags, counters
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_data: port enable
//
//  One request is taken per cycle unless the result path stalls. Ring state
//  updates at the accept edge, the storage read of a cpu read or pop finishes
//  in the registered read port of the ring RAM, and the result register
//  follows it.
//  Reset is synchronous: indices, flags and counters clear, the port enable
//  sets; ring storage is not cleared since entries are only read after
//  being written. A stalled result holds the staging register, and the input
//  then stalls.
`default_nettype none

module byte_pipe_dual_ring_port_core
  import bpdrp_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request: tdata [7:0] data_byte, [8] link_flag, [15:9] zero
  //          tuser [3:0] func
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // result: tdata [7:0] read_byte, [8] done_res, [21:9] rx_free,
  //         [32:22] tx_used, [33] reset_requested, [34] link_is_up,
  //         [35] tx_pending, [67:36] to_cpu_count, [99:68] from_cpu_count,
  //         [103:100] zero
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  // configuration: port_enabled
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  // ring slot advance: wraps at the depth and restarts when the index wraps
  function automatic logic [RX_AW-1:0] rx_slot_inc(input logic [31:0] idx,
                                                   input logic [RX_AW-1:0] slot);
    logic [RX_AW-1:0] s;
    s = (slot == RX_AW'(RX_DEPTH - 1)) ? '0 : slot + RX_AW'(1);
    return (idx == '1) ? '0 : s;
  endfunction

  function automatic logic [TX_AW-1:0] tx_slot_inc(input logic [31:0] idx,
                                                   input logic [TX_AW-1:0] slot);
    logic [TX_AW-1:0] s;
    s = (slot == TX_AW'(TX_DEPTH - 1)) ? '0 : slot + TX_AW'(1);
    return (idx == '1) ? '0 : s;
  endfunction

  // ring indices, with their slot in storage kept alongside
  logic [31:0]      rx_wi_r, rx_wi_nxt, rx_ri_r, rx_ri_nxt, rx_mark_r, rx_mark_nxt;
  logic [31:0]      tx_wi_r, tx_wi_nxt, tx_ri_r, tx_ri_nxt, tx_mark_r, tx_mark_nxt;
  logic [RX_AW-1:0] rx_ws_r, rx_ws_nxt, rx_rs_r, rx_rs_nxt, rx_ms_r, rx_ms_nxt;
  logic [TX_AW-1:0] tx_ws_r, tx_ws_nxt, tx_rs_r, tx_rs_nxt, tx_ms_r, tx_ms_nxt;
  logic             rx_skip_r, rx_skip_nxt, tx_skip_r, tx_skip_nxt;
  logic             rst_wait_r, rst_wait_nxt, link_r, link_nxt;
  logic             notice_r, notice_nxt, port_en_r;
  logic [CNT_W-1:0] dlv_r, dlv_nxt, acc_r, acc_nxt;

  // request fields
  logic [3:0] func;
  logic [7:0] data_byte;
  logic       link_flag;
  logic       in_acc;

  // read side after a pending skip is taken
  logic [31:0]      rx_ri_sk, tx_ri_sk, tx_ri_adv;
  logic [RX_AW-1:0] rx_rs_sk;
  logic [TX_AW-1:0] tx_rs_sk, tx_rs_adv;
  logic             tx_adv_ok;

  // storage ports
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] rx_rdata, tx_rdata;

  // staging and result registers
  stage_t                  st_r, st_nxt;
  logic                    st_valid_r, st_valid_nxt, st_adv;
  logic                    out_valid_r, out_valid_nxt, out_adv;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [7:0]              res_byte;
  logic [31:0]             rx_free_w, tx_used_w;

  assign func      = in_tuser;
  assign data_byte = in_tdata[7:0];
  assign link_flag = in_tdata[8];

  // handshakes: the staging register frees when the result register can load
  assign out_adv   = !out_valid_r || out_tready;
  assign st_adv    = st_valid_r && out_adv;
  assign in_tready = !st_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // lazy flush: move the consumer to the recorded mark only if it is ahead
  always_comb begin
    if (rx_skip_r && mark_ahead(rx_ri_r, rx_mark_r)) begin
      rx_ri_sk = rx_mark_r;
      rx_rs_sk = rx_ms_r;
    end else begin
      rx_ri_sk = rx_ri_r;
      rx_rs_sk = rx_rs_r;
    end
    tx_adv_ok = mark_ahead(tx_ri_r, tx_mark_r);
    tx_ri_adv = tx_adv_ok ? tx_mark_r : tx_ri_r;
    tx_rs_adv = tx_adv_ok ? tx_ms_r : tx_rs_r;
    tx_ri_sk  = tx_skip_r ? tx_ri_adv : tx_ri_r;
    tx_rs_sk  = tx_skip_r ? tx_rs_adv : tx_rs_r;
  end

  // ring update for the request at the accept edge
  always_comb begin
    rx_wi_nxt    = rx_wi_r;
    rx_ri_nxt    = rx_ri_r;
    rx_mark_nxt  = rx_mark_r;
    rx_ws_nxt    = rx_ws_r;
    rx_rs_nxt    = rx_rs_r;
    rx_ms_nxt    = rx_ms_r;
    tx_wi_nxt    = tx_wi_r;
    tx_ri_nxt    = tx_ri_r;
    tx_mark_nxt  = tx_mark_r;
    tx_ws_nxt    = tx_ws_r;
    tx_rs_nxt    = tx_rs_r;
    tx_ms_nxt    = tx_ms_r;
    rx_skip_nxt  = rx_skip_r;
    tx_skip_nxt  = tx_skip_r;
    rst_wait_nxt = rst_wait_r;
    link_nxt     = link_r;
    notice_nxt   = notice_r;
    dlv_nxt      = dlv_r;
    acc_nxt      = acc_r;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    st_nxt         = st_r;
    st_nxt.rd_byte = STATUS_IDLE;
    st_nxt.src     = SRC_NONE;
    st_nxt.done    = 1'b0;

    if (in_acc) begin
      case (func)
        FN_STATUS: begin
          rx_ri_nxt   = rx_ri_sk;
          rx_rs_nxt   = rx_rs_sk;
          rx_skip_nxt = 1'b0;
          st_nxt.rd_byte = (rx_wi_r != rx_ri_sk) ? STATUS_READY : STATUS_IDLE;
        end
        FN_CPU_RD: begin
          rx_ri_nxt   = rx_ri_sk;
          rx_rs_nxt   = rx_rs_sk;
          rx_skip_nxt = 1'b0;
          if (rx_wi_r != rx_ri_sk) begin
            rx_re       = 1'b1;
            rx_ri_nxt   = rx_ri_sk + 32'd1;
            rx_rs_nxt   = rx_slot_inc(rx_ri_sk, rx_rs_sk);
            dlv_nxt     = dlv_r + CNT_W'(1);
            st_nxt.src  = SRC_RX;
            st_nxt.done = 1'b1;
          end
        end
        FN_CPU_WR: begin
          if ((tx_wi_r - tx_ri_r) < 32'(TX_DEPTH)) begin
            tx_we       = 1'b1;
            tx_wi_nxt   = tx_wi_r + 32'd1;
            tx_ws_nxt   = tx_slot_inc(tx_wi_r, tx_ws_r);
            acc_nxt     = acc_r + CNT_W'(1);
            notice_nxt  = 1'b1;
            st_nxt.done = 1'b1;
          end
        end
        FN_CPU_RST: begin
          if (port_en_r) begin
            rx_ri_nxt    = rx_wi_r;
            rx_rs_nxt    = rx_ws_r;
            tx_mark_nxt  = tx_wi_r;
            tx_ms_nxt    = tx_ws_r;
            tx_skip_nxt  = 1'b1;
            rst_wait_nxt = 1'b1;
          end
        end
        FN_NOTIFY: begin
          notice_nxt = 1'b0;
        end
        FN_POP: begin
          tx_ri_nxt   = tx_ri_sk;
          tx_rs_nxt   = tx_rs_sk;
          tx_skip_nxt = 1'b0;
          if (tx_wi_r != tx_ri_sk) begin
            tx_re       = 1'b1;
            tx_ri_nxt   = tx_ri_sk + 32'd1;
            tx_rs_nxt   = tx_slot_inc(tx_ri_sk, tx_rs_sk);
            st_nxt.src  = SRC_TX;
            st_nxt.done = 1'b1;
          end
        end
        FN_PUSH: begin
          if ((rx_wi_r - rx_ri_r) < 32'(RX_DEPTH)) begin
            rx_we       = 1'b1;
            rx_wi_nxt   = rx_wi_r + 32'd1;
            rx_ws_nxt   = rx_slot_inc(rx_wi_r, rx_ws_r);
            st_nxt.done = 1'b1;
          end
        end
        FN_CLR_RST: begin
          if (rst_wait_r) begin
            tx_ri_nxt    = tx_ri_adv;
            tx_rs_nxt    = tx_rs_adv;
            tx_skip_nxt  = 1'b0;
            rst_wait_nxt = 1'b0;
          end
        end
        FN_LINK_SET: begin
          if (!link_flag) begin
            // link loss: finish a pending reset, else drop transmit data
            if (rst_wait_r) begin
              tx_ri_nxt    = tx_ri_adv;
              tx_rs_nxt    = tx_rs_adv;
              tx_skip_nxt  = 1'b0;
              rst_wait_nxt = 1'b0;
            end else begin
              tx_ri_nxt = tx_wi_r;
              tx_rs_nxt = tx_ws_r;
            end
            rx_mark_nxt = rx_wi_r;
            rx_ms_nxt   = rx_ws_r;
            rx_skip_nxt = 1'b1;
          end
          link_nxt = link_flag;
        end
        default: begin
          // query and unused codes change nothing
        end
      endcase
    end

    rx_free_w        = 32'(RX_DEPTH) - (rx_wi_nxt - rx_ri_nxt);
    tx_used_w        = tx_wi_nxt - tx_ri_nxt;
    st_nxt.rx_free   = rx_free_w[RXF_W-1:0];
    st_nxt.tx_used   = tx_used_w[TXU_W-1:0];
    st_nxt.rst_req   = rst_wait_nxt;
    st_nxt.link_up   = link_nxt;
    st_nxt.tx_pend   = notice_nxt;
    st_nxt.to_cpu    = dlv_nxt;
    st_nxt.from_cpu  = acc_nxt;
  end

  // result assembly: pick the storage byte once the RAM read has landed
  always_comb begin
    case (st_r.src)
      SRC_RX:  res_byte = rx_rdata;
      SRC_TX:  res_byte = tx_rdata;
      default: res_byte = st_r.rd_byte;
    endcase
    out_data_nxt = {4'b0000, st_r.from_cpu, st_r.to_cpu, st_r.tx_pend, st_r.link_up,
                    st_r.rst_req, st_r.tx_used, st_r.rx_free, st_r.done, res_byte};
    st_valid_nxt  = in_acc ? 1'b1 : (st_adv ? 1'b0 : st_valid_r);
    out_valid_nxt = st_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  bpdrp_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_ws_r),
    .wdata (data_byte),
    .re    (rx_re),
    .raddr (rx_rs_sk),
    .rdata (rx_rdata)
  );

  bpdrp_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_ws_r),
    .wdata (data_byte),
    .re    (tx_re),
    .raddr (tx_rs_sk),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wi_r     <= '0;
      rx_ri_r     <= '0;
      rx_mark_r   <= '0;
      rx_ws_r     <= '0;
      rx_rs_r     <= '0;
      rx_ms_r     <= '0;
      tx_wi_r     <= '0;
      tx_ri_r     <= '0;
      tx_mark_r   <= '0;
      tx_ws_r     <= '0;
      tx_rs_r     <= '0;
      tx_ms_r     <= '0;
      rx_skip_r   <= 1'b0;
      tx_skip_r   <= 1'b0;
      rst_wait_r  <= 1'b0;
      link_r      <= 1'b0;
      notice_r    <= 1'b0;
      dlv_r       <= '0;
      acc_r       <= '0;
      port_en_r   <= 1'b1;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_wi_r     <= rx_wi_nxt;
      rx_ri_r     <= rx_ri_nxt;
      rx_mark_r   <= rx_mark_nxt;
      rx_ws_r     <= rx_ws_nxt;
      rx_rs_r     <= rx_rs_nxt;
      rx_ms_r     <= rx_ms_nxt;
      tx_wi_r     <= tx_wi_nxt;
      tx_ri_r     <= tx_ri_nxt;
      tx_mark_r   <= tx_mark_nxt;
      tx_ws_r     <= tx_ws_nxt;
      tx_rs_r     <= tx_rs_nxt;
      tx_ms_r     <= tx_ms_nxt;
      rx_skip_r   <= rx_skip_nxt;
      tx_skip_r   <= tx_skip_nxt;
      rst_wait_r  <= rst_wait_nxt;
      link_r      <= link_nxt;
      notice_r    <= notice_nxt;
      dlv_r       <= dlv_nxt;
      acc_r       <= acc_nxt;
      st_valid_r  <= st_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        port_en_r <= cfg_data;
      end
    end
  end

  // payload registers: loaded on their stage's advance, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r <= st_nxt;
    end
    if (st_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // rings never hold more than their depth
  a_rx_level: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_wi_r - rx_ri_r) <= 32'(RX_DEPTH))
    else $error("receive ring over depth");

  a_tx_level: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_wi_r - tx_ri_r) <= 32'(TX_DEPTH))
    else $error("transmit ring over depth");

  // a transmit flush mark only exists while a cpu reset waits
  a_tx_skip_wait: assert property (@(posedge clk) disable iff (!rst_n)
    tx_skip_r |-> rst_wait_r)
    else $error("transmit mark without pending reset");

  // a blocked result keeps the staging register full and the input stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request taken while pipe is blocked");

endmodule

`default_nettype wire
